// ===== rtl/md5_pkg.sv =====
// md5_pkg: shared types, constants and round functions for the md5 digest block
// depends on nothing; used by every rtl file of the block except md5_checker
`default_nettype none

package md5_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned BlockWrds = 16;
  localparam int unsigned AddrW     = $clog2(BlockWrds);
  localparam int unsigned LaneCnt   = WordW / 8;
  localparam int unsigned CountW    = 61;
  localparam int unsigned RoundW    = 6;

  typedef logic [WordW-1:0] word_t;
  typedef logic [3:0][WordW-1:0] quad_t;

  // chaining value after reset and after each digest
  localparam word_t InitA = 32'h67452301;
  localparam word_t InitB = 32'hefcdab89;
  localparam word_t InitC = 32'h98badcfe;
  localparam word_t InitD = 32'h10325476;

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenFirstPos = 6'd56;
  localparam logic [AddrW-1:0] LastWord = 4'hf;
  localparam logic [AddrW-1:0] LenLoWord = 4'he;
  localparam logic [RoundW-1:0] LastRound = 6'd63;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PAD,
    S_COMP
  } top_state_e;

  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_DONE
  } cmp_state_e;

  typedef struct packed {
    logic start;
    logic ack;
  } cmp_ctl_t;

  typedef struct packed {
    logic done;
  } cmp_stat_t;

  function automatic word_t step_const(input logic [RoundW-1:0] r);
    word_t k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [3:0] sel);
    logic [4:0] s;
    case (sel)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word used by a given round
  function automatic logic [AddrW-1:0] msg_index(input logic [RoundW-1:0] r);
    logic [3:0] lo;
    logic [3:0] g;
    lo = r[3:0];
    case (r[5:4])
      2'd0:    g = lo;
      2'd1:    g = lo + (lo << 2) + 4'd1;
      2'd2:    g = lo + (lo << 1) + 4'd5;
      default: g = (lo << 3) - lo;
    endcase
    return g;
  endfunction

  function automatic word_t rotl32(input word_t x, input logic [4:0] s);
    logic [2*WordW-1:0] t;
    t = {x, x} << s;
    return t[2*WordW-1:WordW];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/md5_block_ram.sv =====
// md5_block_ram: 16 x 32 message block store, byte-lane writes, registered read
// depends on md5_pkg
`default_nettype none

module md5_block_ram (
  input  wire logic                            clk_i,
  input  wire logic                            we_i,
  input  wire logic [md5_pkg::LaneCnt-1:0]     be_i,
  input  wire logic [md5_pkg::AddrW-1:0]       waddr_i,
  input  wire md5_pkg::word_t                  wdata_i,
  input  wire logic [md5_pkg::AddrW-1:0]       raddr_i,
  output md5_pkg::word_t                       rdata_o
);

  md5_pkg::word_t mem_q [md5_pkg::BlockWrds];
  md5_pkg::word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int k = 0; k < md5_pkg::LaneCnt; k++) begin
        if (be_i[k]) begin
          mem_q[waddr_i][8*k +: 8] <= wdata_i[8*k +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/md5_compress.sv =====
// md5_compress: 64-round compression, one round per cycle, block words from the ram
// depends on md5_pkg
`default_nettype none

module md5_compress (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire md5_pkg::cmp_ctl_t           ctl_i,
  input  wire md5_pkg::quad_t              chain_i,
  input  wire md5_pkg::word_t              rd_data_i,
  output logic [md5_pkg::AddrW-1:0]        rd_addr_o,
  output md5_pkg::cmp_stat_t               stat_o,
  output md5_pkg::quad_t                   wv_o
);

  md5_pkg::cmp_state_e state_q, state_d;
  logic [md5_pkg::RoundW-1:0] round_q, round_d;
  md5_pkg::quad_t wv_q, wv_d;

  md5_pkg::word_t a, b, c, d, f, sum, rot;

  always_comb begin
    a = wv_q[0];
    b = wv_q[1];
    c = wv_q[2];
    d = wv_q[3];
    case (round_q[5:4])
      2'd0:    f = d ^ (b & (c ^ d));
      2'd1:    f = (d & b) | (~d & c);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    sum = a + f + md5_pkg::step_const(round_q) + rd_data_i;
    rot = md5_pkg::rotl32(sum, md5_pkg::rot_amount({round_q[5:4], round_q[1:0]}));
  end

  always_comb begin
    state_d   = state_q;
    round_d   = round_q;
    wv_d      = wv_q;
    // prefetch the word for the following round
    rd_addr_o = md5_pkg::msg_index(md5_pkg::RoundW'(round_q + 1'b1));
    unique case (state_q)
      md5_pkg::C_IDLE: begin
        rd_addr_o = md5_pkg::msg_index('0);
        if (ctl_i.start) begin
          wv_d    = chain_i;
          round_d = '0;
          state_d = md5_pkg::C_RUN;
        end
      end
      md5_pkg::C_RUN: begin
        wv_d[0] = d;
        wv_d[1] = b + rot;
        wv_d[2] = b;
        wv_d[3] = c;
        round_d = md5_pkg::RoundW'(round_q + 1'b1);
        if (round_q == md5_pkg::LastRound) begin
          state_d = md5_pkg::C_DONE;
        end
      end
      md5_pkg::C_DONE: begin
        if (ctl_i.ack) begin
          state_d = md5_pkg::C_IDLE;
        end
      end
      default: state_d = md5_pkg::C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= md5_pkg::C_IDLE;
      round_q <= '0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wv_q <= wv_d;
  end

  assign stat_o.done = (state_q == md5_pkg::C_DONE);
  assign wv_o        = wv_q;

endmodule

`default_nettype wire

// ===== rtl/md5_message_digest.sv =====
// md5_message_digest: top level of the md5 digest engine, byte packing, padding,
// chaining value and digest output; depends on md5_pkg, md5_block_ram, md5_compress
//
// usage
// - input channel (in_valid_i / in_ready_o): one word per handshake holding a
//   message byte (when byte_present_i is set) and an end-of-message flag; a word
//   with only the end flag closes the message, so an empty message is legal
// - output channel (out_valid_o / out_ready_i): four digest words per message,
//   word_index_o 0..3, least significant word first, last_word_o on word 3
// - byte words are taken while the engine is idle; the byte that fills a 64-byte
//   block holds in_ready_o low while the compression runs: one round per cycle,
//   each round taking its message word from a block ram read issued the round before
// - after the end word: padding writes of up to 16 ram words (one ram word per
//   cycle), then the compression, done twice when the length does not fit the
//   last block
// - the digest is held in its own register, so the next message may start while
//   the receiver stalls; only a second digest waits for the first to drain
// - reset: chaining value to the standard initial words, byte count to zero,
//   no digest pending; the block ram holds garbage and is always rewritten
//   before it is read
`default_nettype none

module md5_message_digest (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        byte_present_i,
  input  wire logic        end_of_message_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      digest_word_o,
  output logic [1:0]       word_index_o,
  output logic             last_word_o
);

  localparam md5_pkg::quad_t ChainInit =
    {md5_pkg::InitD, md5_pkg::InitC, md5_pkg::InitB, md5_pkg::InitA};

  md5_pkg::top_state_e state_q, state_d;

  // message length in bytes, wraps modulo 2^61
  logic [md5_pkg::CountW-1:0] count_q, count_d, count_next;
  logic [5:0] pos, pos_next;

  md5_pkg::quad_t chain_q, chain_d;
  md5_pkg::quad_t digest_q, digest_d;
  logic out_valid_q, out_valid_d;
  logic [1:0] out_idx_q, out_idx_d;

  // padding sequencer
  logic [md5_pkg::AddrW-1:0] pad_word_q, pad_word_d;
  logic [1:0] pad_lane_q, pad_lane_d;
  logic pad_mark_q, pad_mark_d;   // current pad word takes the 0x80 marker
  logic pad_len_q, pad_len_d;     // this block carries the bit length
  logic marked_q, marked_d;       // marker already written for this message
  logic end_pend_q, end_pend_d;   // message closed, padding still owed
  logic final_q, final_d;         // running compression yields the digest

  // block ram ports
  logic ram_we;
  logic [md5_pkg::LaneCnt-1:0] ram_be;
  logic [md5_pkg::AddrW-1:0] ram_waddr, ram_raddr;
  md5_pkg::word_t ram_wdata, ram_rdata;

  md5_pkg::cmp_ctl_t cmp_ctl;
  md5_pkg::cmp_stat_t cmp_stat;
  md5_pkg::quad_t wv;

  md5_pkg::word_t len_lo, len_hi;
  logic in_fire, out_fire;

  assign in_ready_o = (state_q == md5_pkg::S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_fire   = out_valid_q & out_ready_i;

  assign pos        = count_q[5:0];
  assign count_next = byte_present_i ? md5_pkg::CountW'(count_q + 1'b1) : count_q;
  assign pos_next   = count_next[5:0];

  // 64-bit bit length, little-endian words
  assign len_lo = {count_q[28:0], 3'b000};
  assign len_hi = count_q[md5_pkg::CountW-1:29];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    chain_d     = chain_q;
    digest_d    = digest_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    pad_word_d  = pad_word_q;
    pad_lane_d  = pad_lane_q;
    pad_mark_d  = pad_mark_q;
    pad_len_d   = pad_len_q;
    marked_d    = marked_q;
    end_pend_d  = end_pend_q;
    final_d     = final_q;
    ram_we      = 1'b0;
    ram_be      = '0;
    ram_waddr   = pad_word_q;
    ram_wdata   = '0;
    cmp_ctl     = '0;

    // digest drain
    if (out_fire) begin
      out_idx_d = 2'(out_idx_q + 1'b1);
      if (out_idx_q == 2'd3) begin
        out_valid_d = 1'b0;
      end
    end

    unique case (state_q)
      md5_pkg::S_IDLE: begin
        if (in_fire) begin
          if (byte_present_i) begin
            ram_we    = 1'b1;
            ram_waddr = pos[5:2];
            ram_be    = md5_pkg::LaneCnt'(4'b0001 << pos[1:0]);
            ram_wdata = {md5_pkg::LaneCnt{data_byte_i}};
            count_d   = count_next;
          end
          if (byte_present_i && pos == 6'd63) begin
            // block full; padding, if any, follows the compression
            cmp_ctl.start = 1'b1;
            final_d       = 1'b0;
            end_pend_d    = end_of_message_i;
            state_d       = md5_pkg::S_COMP;
          end else if (end_of_message_i) begin
            pad_word_d = pos_next[5:2];
            pad_lane_d = pos_next[1:0];
            pad_mark_d = 1'b1;
            pad_len_d  = (pos_next < md5_pkg::LenFirstPos);
            end_pend_d = 1'b1;
            state_d    = md5_pkg::S_PAD;
          end
        end
      end

      md5_pkg::S_PAD: begin
        ram_we    = 1'b1;
        ram_waddr = pad_word_q;
        ram_be    = '1;
        ram_wdata = '0;
        if (pad_len_q && pad_word_q == md5_pkg::LenLoWord) begin
          ram_wdata = len_lo;
        end else if (pad_len_q && pad_word_q == md5_pkg::LastWord) begin
          ram_wdata = len_hi;
        end else if (pad_mark_q) begin
          // marker byte, zero fill above it, earlier bytes kept
          ram_be    = md5_pkg::LaneCnt'(4'b1111 << pad_lane_q);
          ram_wdata = md5_pkg::WordW'(md5_pkg::PadMark) << {pad_lane_q, 3'b000};
        end
        marked_d   = marked_q | pad_mark_q;
        pad_mark_d = 1'b0;
        if (pad_word_q == md5_pkg::LastWord) begin
          cmp_ctl.start = 1'b1;
          final_d       = pad_len_q;
          state_d       = md5_pkg::S_COMP;
        end else begin
          pad_word_d = md5_pkg::AddrW'(pad_word_q + 1'b1);
        end
      end

      md5_pkg::S_COMP: begin
        if (cmp_stat.done) begin
          if (final_q) begin
            // digest waits until the previous one has drained
            if (!out_valid_q) begin
              cmp_ctl.ack = 1'b1;
              for (int i = 0; i < 4; i++) begin
                digest_d[i] = chain_q[i] + wv[i];
              end
              out_valid_d = 1'b1;
              out_idx_d   = '0;
              chain_d     = ChainInit;
              count_d     = '0;
              end_pend_d  = 1'b0;
              marked_d    = 1'b0;
              state_d     = md5_pkg::S_IDLE;
            end
          end else begin
            cmp_ctl.ack = 1'b1;
            for (int i = 0; i < 4; i++) begin
              chain_d[i] = chain_q[i] + wv[i];
            end
            if (end_pend_q) begin
              // next block starts at byte zero and ends with the length
              pad_word_d = '0;
              pad_lane_d = '0;
              pad_mark_d = ~marked_q;
              pad_len_d  = 1'b1;
              state_d    = md5_pkg::S_PAD;
            end else begin
              state_d = md5_pkg::S_IDLE;
            end
          end
        end
      end

      default: state_d = md5_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= md5_pkg::S_IDLE;
      count_q     <= '0;
      chain_q     <= ChainInit;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      pad_mark_q  <= 1'b0;
      pad_len_q   <= 1'b0;
      marked_q    <= 1'b0;
      end_pend_q  <= 1'b0;
      final_q     <= 1'b0;
      pad_word_q  <= '0;
      pad_lane_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      chain_q     <= chain_d;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
      pad_mark_q  <= pad_mark_d;
      pad_len_q   <= pad_len_d;
      marked_q    <= marked_d;
      end_pend_q  <= end_pend_d;
      final_q     <= final_d;
      pad_word_q  <= pad_word_d;
      pad_lane_q  <= pad_lane_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digest_q <= digest_d;
  end

  md5_block_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .be_i    (ram_be),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  md5_compress u_cmp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (cmp_ctl),
    .chain_i   (chain_q),
    .rd_data_i (ram_rdata),
    .rd_addr_o (ram_raddr),
    .stat_o    (cmp_stat),
    .wv_o      (wv)
  );

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = digest_q[out_idx_q];
  assign word_index_o  = out_idx_q;
  assign last_word_o   = (out_idx_q == 2'd3);

endmodule

`default_nettype wire

// ===== rtl/md5_checker.sv =====
// md5_checker: port-level assertions for md5_message_digest, bound to the top level
// depends on md5_message_digest
`default_nettype none

module md5_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        end_of_message_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] digest_word_o,
  input wire logic [1:0]  word_index_o,
  input wire logic        last_word_o
);

  // stalled digest word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(digest_word_o)
      && $stable(word_index_o))
    else $error("digest word changed while stalled");

  // the four words of a digest come without a gap, in index order
  a_out_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_word_o |=>
      out_valid_o && word_index_o == 2'($past(word_index_o) + 2'd1))
    else $error("digest words out of order");

  // a new digest never follows the last word in the next cycle
  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_word_o |=> !out_valid_o)
    else $error("digest started right after last word");

  // closing a message always starts padding or a compression, so input stalls
  a_end_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && end_of_message_i |=> !in_ready_o)
    else $error("input ready right after end of message");

endmodule

bind md5_message_digest md5_checker u_md5_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .end_of_message_i (end_of_message_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .digest_word_o    (digest_word_o),
  .word_index_o     (word_index_o),
  .last_word_o      (last_word_o)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench for md5_message_digest: random and directed byte streams, split into messages,
// checked against an md5 predictor in this file; needs md5_pkg and the rtl of the block
`timescale 1ns / 100ps

module testbench;

  // one input word: a message byte and/or the end-of-message flag
  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       eom;
  } msg_word_t;

  // one digest word as the block should emit it
  typedef struct {
    md5_pkg::word_t word;
    logic [1:0]     idx;
    logic           last;
  } digest_exp_t;

  localparam int unsigned StallCycles = 1500;
  localparam int unsigned NumItems    = 320;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_present = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_ready = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [31:0] digest_word_o;
  logic [1:0]  word_index_o;
  logic        last_word_o;

  msg_word_t   msg_word_q[$];
  digest_exp_t expected_digest_q[$];

  int unsigned n_items = 0;
  int unsigned n_accepted = 0;
  int unsigned hold_at = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned n_fail = 0;
  int unsigned n_msgs = 0;
  int unsigned n_bytes = 0;
  int unsigned n_digest_words = 0;
  int unsigned n_in_stalls = 0;

  // predictor state: chaining value, current block and message length in bytes
  md5_pkg::word_t chain_val [4];
  md5_pkg::word_t blk_w [16];
  logic [60:0]    msg_bytes;

  md5_pkg::word_t round_k [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  int unsigned rot_s [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  md5_message_digest DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte),
    .byte_present_i  (byte_present),
    .end_of_message_i(end_of_message),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .digest_word_o   (digest_word_o),
    .word_index_o    (word_index_o),
    .last_word_o     (last_word_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // md5 predictor
  // ---------------------------------------------------------------------------

  function automatic md5_pkg::word_t rol(input md5_pkg::word_t x, input int unsigned s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic clear_message();
    chain_val[0] = md5_pkg::InitA;
    chain_val[1] = md5_pkg::InitB;
    chain_val[2] = md5_pkg::InitC;
    chain_val[3] = md5_pkg::InitD;
    foreach (blk_w[j]) blk_w[j] = '0;
    msg_bytes = '0;
  endtask

  task automatic put_byte(input int unsigned pos, input logic [7:0] v);
    blk_w[pos / 4][(pos % 4) * 8 +: 8] = v;
  endtask

  // 64 rounds over blk_w, folded into the chaining value
  task automatic md5_compress();
    md5_pkg::word_t a, b, c, d, f, tmp;
    int unsigned r, g;
    a = chain_val[0];
    b = chain_val[1];
    c = chain_val[2];
    d = chain_val[3];
    for (r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      tmp = d;
      d = c;
      c = b;
      b = b + rol(a + f + round_k[r] + blk_w[g], rot_s[(r / 16) * 4 + r % 4]);
      a = tmp;
    end
    chain_val[0] += a;
    chain_val[1] += b;
    chain_val[2] += c;
    chain_val[3] += d;
  endtask

  // takes one accepted word; on end of message queues the four digest words
  task automatic md5_absorb(input logic [7:0] b, input logic has_byte, input logic eom);
    int unsigned pos, i;
    logic [63:0] bit_len;
    digest_exp_t e;
    if (has_byte) begin
      pos = msg_bytes[5:0];
      put_byte(pos, b);
      msg_bytes = msg_bytes + 1'b1;
      n_bytes++;
      if (pos == 63) md5_compress();
    end
    if (eom) begin
      pos = msg_bytes[5:0];
      put_byte(pos, md5_pkg::PadMark);
      for (i = pos + 1; i < 64; i++) put_byte(i, 8'h00);
      // no room for the length: pad block first, length goes in a block of its own
      if (pos >= 56) begin
        md5_compress();
        foreach (blk_w[j]) blk_w[j] = '0;
      end
      bit_len = {msg_bytes, 3'b000};
      blk_w[14] = bit_len[31:0];
      blk_w[15] = bit_len[63:32];
      md5_compress();
      for (i = 0; i < 4; i++) begin
        e.word = chain_val[i];
        e.idx  = i[1:0];
        e.last = (i == 3);
        expected_digest_q.push_back(e);
      end
      n_msgs++;
      clear_message();
    end
  endtask

  // ---------------------------------------------------------------------------
  // idling: sender 38% / receiver 64%, then swapped, then no idling at all
  // ---------------------------------------------------------------------------

  function automatic int unsigned tx_idle_pct();
    if (n_accepted < n_items / 3) return 38;
    if (n_accepted < (2 * n_items) / 3) return 64;
    return 0;
  endfunction

  function automatic int unsigned rx_idle_pct();
    if (n_accepted < n_items / 3) return 64;
    if (n_accepted < (2 * n_items) / 3) return 38;
    return 0;
  endfunction

  // driver: payload may change only when nothing is offered or the word was taken
  always @(posedge clk_i) begin
    msg_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready_o) begin
      if (msg_word_q.size() != 0 && $urandom_range(99) >= tx_idle_pct()) begin
        w = msg_word_q.pop_front();
        data_byte      <= w.data;
        byte_present   <= w.present;
        end_of_message <= w.eom;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off late in the run, while the
  // sender keeps going, so that a finished digest backs up and input stalls
  always @(posedge clk_i) begin
    logic starting;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      starting = !hold_done && hold_left == 0 && n_accepted >= hold_at;
      if (starting) begin
        hold_left <= StallCycles;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      out_ready <= !starting && hold_left <= 1 && $urandom_range(99) >= rx_idle_pct();
    end
  end

  // monitor: checks accepted digest words first, then feeds the predictor with
  // the accepted input word, so ordering inside the edge does not matter
  always @(posedge clk_i) begin
    digest_exp_t want;
    if (rst_n) begin
      if (out_valid_o && out_ready) begin
        n_digest_words++;
        if (expected_digest_q.size() == 0) begin
          $display("%0t: digest word %h (index %0d) with none expected",
                   $time, digest_word_o, word_index_o);
          n_fail++;
        end else begin
          want = expected_digest_q.pop_front();
          if (digest_word_o !== want.word) begin
            $display("%0t: digest word: expected %h, got %h", $time, want.word, digest_word_o);
            n_fail++;
          end
          if (word_index_o !== want.idx) begin
            $display("%0t: word index: expected %0d, got %0d", $time, want.idx, word_index_o);
            n_fail++;
          end
          if (last_word_o !== want.last) begin
            $display("%0t: last word flag: expected %b, got %b", $time, want.last, last_word_o);
            n_fail++;
          end
        end
      end
      if (in_valid && !in_ready_o) n_in_stalls++;
      if (in_valid && in_ready_o) begin
        md5_absorb(data_byte, byte_present, end_of_message);
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  task automatic push_word(input logic [7:0] d, input logic p, input logic e);
    msg_word_t w;
    w.data    = d;
    w.present = p;
    w.eom     = e;
    msg_word_q.push_back(w);
  endtask

  initial begin
    int unsigned boundary_len [9];
    int unsigned room, len, k, longest;
    logic end_with_byte;

    boundary_len = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
    clear_message();

    // empty message, twice in a row
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'hff, 1'b0, 1'b1);
    // single byte carrying the end flag
    push_word(8'h61, 1'b1, 1'b1);
    // word with neither byte nor end, then extreme bytes, another empty word, end alone with junk data
    push_word(8'h5a, 1'b0, 1'b0);
    push_word(8'h00, 1'b1, 1'b0);
    push_word(8'hff, 1'b1, 1'b0);
    push_word(8'ha5, 1'b0, 1'b0);
    push_word(8'hff, 1'b0, 1'b1);
    // "abc", end flag on the last byte
    push_word(8'h61, 1'b1, 1'b0);
    push_word(8'h62, 1'b1, 1'b0);
    push_word(8'h63, 1'b1, 1'b1);
    // alternating bit patterns, separate end word
    push_word(8'h55, 1'b1, 1'b0);
    push_word(8'haa, 1'b1, 1'b0);
    push_word(8'h00, 1'b0, 1'b1);

    // random messages: mostly short, some around the block and padding boundaries;
    // the last one is trimmed so the total stays near the planned word count
    longest = 0;
    while (msg_word_q.size() < NumItems) begin
      if ($urandom_range(4) == 0) len = boundary_len[$urandom_range(8)];
      else len = $urandom_range(20);
      room = NumItems - msg_word_q.size();
      if (len > room) len = room;
      if (len > longest) longest = len;
      end_with_byte = (len != 0) && ($urandom_range(1) == 1);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(19) == 0) push_word(8'($urandom_range(255)), 1'b0, 1'b0);
        push_word(8'($urandom_range(255)), 1'b1, end_with_byte && k == len - 1);
      end
      if (!end_with_byte) begin
        push_word(8'($urandom_range(255)), 1'b0, 1'b1);
      end
    end

    n_items = msg_word_q.size();
    hold_at = (3 * n_items) / 4;

    while (!rst_n) @(negedge clk_i);
    while (n_accepted != n_items || expected_digest_q.size() != 0) @(negedge clk_i);
    // let any stray output show up before judging
    repeat (300) @(negedge clk_i);

    $display("run covered %0d messages, %0d bytes, longest random message %0d bytes",
             n_msgs, n_bytes, longest);
    $display("%0d digest words checked, input held off for %0d cycles",
             n_digest_words, n_in_stalls);
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d of %0d words accepted", n_accepted, n_items);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
